>>> src/hash64_four_lane_mix_macros.svh
// Assertion macros used by the hash block's back end.
`ifndef HASH64_FOUR_LANE_MIX_MACROS_SVH
`define HASH64_FOUR_LANE_MIX_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define H64_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define H64_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define H64_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/h64flm_pkg.sv
// Types, constants and mixing functions of the four-lane hash block.
package h64flm_pkg;

	localparam logic [63:0] HASH_MAGIC = 64'hde79_d374_7be3_56ce;

	// Rotation amounts of the twelve mix steps.
	localparam logic [5:0] MIX_ROT [12] = '{
		6'd50, 6'd52, 6'd30, 6'd41, 6'd54, 6'd48,
		6'd38, 6'd37, 6'd62, 6'd34, 6'd5,  6'd36
	};

	// Two mix steps run per cycle, so a mix is this many step pairs.
	localparam int MIX_CYCLES = 6;
	localparam logic [2:0] MIX_LAST = 3'(MIX_CYCLES - 1);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		LANE_A = 2'd0,
		LANE_B = 2'd1,
		LANE_C = 2'd2,
		LANE_D = 2'd3
	} lane_t;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} lanes_t;

	// Operation handed from the front to the back.
	typedef struct packed {
		logic        seed;   // load all lanes with value, else add into lane
		lane_t       lane;
		logic [63:0] value;
		logic        mix;    // mix the lanes after the add
		logic        fin;    // finish the message and deliver a hash
		logic        magic;  // add the magic constant to c and d on finish
	} op_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
		logic [127:0] t;
		t = {x, x} << r;
		return t[127:64];
	endfunction

	// One rotate-add-xor step; sel is the step position modulo four.
	function automatic lanes_t mix_step(input lanes_t l, input logic [1:0] sel,
		input logic [5:0] r);
		lanes_t o;
		o = l;
		unique case (sel)
			2'd0: begin
				o.c = rotl(l.c, r) + l.d;
				o.a = l.a ^ o.c;
			end
			2'd1: begin
				o.d = rotl(l.d, r) + l.a;
				o.b = l.b ^ o.d;
			end
			2'd2: begin
				o.a = rotl(l.a, r) + l.b;
				o.c = l.c ^ o.a;
			end
			default: begin
				o.b = rotl(l.b, r) + l.c;
				o.d = l.d ^ o.b;
			end
		endcase
		return o;
	endfunction

	// Steps 2k and 2k+1 of the mix.
	function automatic lanes_t mix_pair(input lanes_t l, input logic [2:0] k);
		lanes_t m;
		m = mix_step(l, {k[0], 1'b0}, MIX_ROT[{k, 1'b0}]);
		return mix_step(m, {k[0], 1'b1}, MIX_ROT[{k, 1'b1}]);
	endfunction

endpackage

>>> src/h64flm_fifo.sv
// Small register queue used between the front, the back and the result port.
module h64flm_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_q];

	// Store a pushed entry.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// Advance pointers and the fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/h64flm_front.sv
// Front end: tracks message position and turns each item into a lane operation.
module h64flm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              command,
	input  logic [63:0]       length,
	input  logic [63:0]       data_word,
	output logic              op_valid,
	output h64flm_pkg::op_t   op
);

	logic [63:0] bytes_left_q;
	logic [1:0]  slot_q;
	logic        open_q;

	logic [63:0] bytes_left_n;
	logic [1:0]  slot_n;
	logic        open_n;

	logic [63:0] group;
	logic        big;
	logic        pair;
	logic [2:0]  full_cnt;
	logic [2:0]  slot_inc;
	logic        short_word;
	logic [63:0] mask;
	logic [63:0] masked;

	// Classify the item against the current group.
	always_comb begin
		group      = bytes_left_q + {59'd0, slot_q, 3'b000};
		big        = (group >= 64'd32);
		pair       = (group >= 64'd16);
		full_cnt   = big ? 3'd4 : 3'd2;
		slot_inc   = {1'b0, slot_q} + 3'd1;
		short_word = (bytes_left_q[63:3] == '0);
		mask       = ~({64{1'b1}} << {bytes_left_q[2:0], 3'b000});
		masked     = short_word ? (data_word & mask) : data_word;

		op_valid     = 1'b0;
		op.seed      = 1'b0;
		op.lane      = h64flm_pkg::LANE_A;
		op.value     = data_word;
		op.mix       = 1'b0;
		op.fin       = 1'b0;
		op.magic     = 1'b0;
		bytes_left_n = bytes_left_q;
		slot_n       = slot_q;
		open_n       = open_q;

		priority if (command == h64flm_pkg::CMD_START) begin
			// Seed the lanes; an empty message finishes at once.
			op_valid     = 1'b1;
			op.seed      = 1'b1;
			op.value     = length + h64flm_pkg::HASH_MAGIC;
			op.fin       = (length == '0);
			op.magic     = 1'b1;
			bytes_left_n = length;
			slot_n       = 2'd0;
			open_n       = (length != '0);
		end else if (!open_q) begin
			// Drop data outside a message.
			op_valid = 1'b0;
		end else if (pair) begin
			// Whole word of a 32-byte group or a 16-byte pair.
			op_valid     = 1'b1;
			op.lane      = h64flm_pkg::lane_t'(slot_q);
			op.mix       = (slot_inc == full_cnt);
			op.fin       = (slot_inc == full_cnt) && (bytes_left_q == 64'd8);
			op.magic     = 1'b1;
			bytes_left_n = bytes_left_q - 64'd8;
			slot_n       = (slot_inc == full_cnt) ? 2'd0 : slot_inc[1:0];
			if (op.fin) begin
				open_n = 1'b0;
			end
		end else begin
			// Tail of 1 to 15 bytes goes into c, then d.
			op_valid = 1'b1;
			op.lane  = (slot_q == 2'd0) ? h64flm_pkg::LANE_C : h64flm_pkg::LANE_D;
			op.value = masked;
			op.fin   = (bytes_left_q <= 64'd8);
			op.magic = (slot_q == 2'd0) && (bytes_left_q < 64'd4);
			if (op.fin) begin
				open_n       = 1'b0;
				bytes_left_n = '0;
				slot_n       = 2'd0;
			end else begin
				bytes_left_n = bytes_left_q - 64'd8;
				slot_n       = 2'd1;
			end
		end
	end

	// Update position on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			slot_q       <= '0;
			open_q       <= 1'b0;
		end else if (accept) begin
			bytes_left_q <= bytes_left_n;
			slot_q       <= slot_n;
			open_q       <= open_n;
		end
	end

endmodule

>>> src/h64flm_back.sv
// Back end: applies lane operations, runs the mixes and forms the hash.
`include "hash64_four_lane_mix_macros.svh"

module h64flm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_empty,
	input  h64flm_pkg::op_t   op,
	output logic              op_pop,
	input  logic              res_full,
	output logic              res_push,
	output logic [63:0]       res_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MIX   = 6'b000010,
		S_MAGIC = 6'b000100,
		S_FMIX  = 6'b001000,
		S_SUM   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                state_q;
	h64flm_pkg::lanes_t    lanes_q;
	logic [2:0]            cnt_q;
	logic                  fin_q;
	logic                  magic_q;
	logic [63:0]           ab_q;
	logic [63:0]           cd_q;

	assign op_pop   = (state_q == S_IDLE) && !op_empty;
	assign res_push = (state_q == S_OUT) && !res_full;
	assign res_data = ab_q + cd_q;

	// Hold the lanes and partial sums; no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (op_pop) begin
					if (op.seed) begin
						lanes_q <= '{a: op.value, b: op.value, c: op.value, d: op.value};
					end else begin
						unique case (op.lane)
							h64flm_pkg::LANE_A: lanes_q.a <= lanes_q.a + op.value;
							h64flm_pkg::LANE_B: lanes_q.b <= lanes_q.b + op.value;
							h64flm_pkg::LANE_C: lanes_q.c <= lanes_q.c + op.value;
							default:            lanes_q.d <= lanes_q.d + op.value;
						endcase
					end
					fin_q   <= op.fin;
					magic_q <= op.magic;
				end
			end
			S_MIX, S_FMIX: begin
				lanes_q <= h64flm_pkg::mix_pair(lanes_q, cnt_q);
			end
			S_MAGIC: begin
				if (magic_q) begin
					lanes_q.c <= lanes_q.c + h64flm_pkg::HASH_MAGIC;
					lanes_q.d <= lanes_q.d + h64flm_pkg::HASH_MAGIC;
				end
			end
			S_SUM: begin
				ab_q <= lanes_q.a + lanes_q.b;
				cd_q <= lanes_q.c + lanes_q.d;
			end
			default: begin
				ab_q <= ab_q;
			end
		endcase
	end

	// Sequence the operation: add, optional mix, optional finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (op_pop) begin
						priority if (op.mix) begin
							state_q <= S_MIX;
						end else if (op.fin) begin
							state_q <= S_MAGIC;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MIX: begin
					if (cnt_q == h64flm_pkg::MIX_LAST) begin
						cnt_q   <= '0;
						state_q <= fin_q ? S_MAGIC : S_IDLE;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_MAGIC: begin
					cnt_q   <= '0;
					state_q <= S_FMIX;
				end
				S_FMIX: begin
					if (cnt_q == h64flm_pkg::MIX_LAST) begin
						cnt_q   <= '0;
						state_q <= S_SUM;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_SUM: begin
					state_q <= S_OUT;
				end
				default: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	`H64_ASSERT_IMP(a_mix_cnt, (state_q == S_MIX) || (state_q == S_FMIX), cnt_q <= h64flm_pkg::MIX_LAST, "mix step count out of range")
	`H64_ASSERT_NXT(a_sum_to_out, state_q == S_SUM, state_q == S_OUT, "sum not followed by output")
	`H64_ASSERT_NXT(a_push_idle, res_push, (state_q == S_IDLE) && !res_push, "hash pushed twice")
	`H64_ASSERT_NXT(a_magic_fmix, state_q == S_MAGIC, (state_q == S_FMIX) && (cnt_q == '0), "finish mix did not start")

endmodule

>>> src/hash64_four_lane_mix.sv
// Top level of the streaming four-lane 64-bit hash block.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  input   | push / full           | command, length, data_word
//  result  | pop / empty           | hash
//
// The front takes one item per cycle while the operation queue has room.
// The back takes a new operation only while idle, not during a lane mix
// (two mix steps a cycle) or while it finishes a message (magic add, final
// mix, sum, push into the result queue).
// Reset clears all control state asynchronously; there is no clearing pass.
// Results wait in the result queue; when it fills, the back and then the
// front stall on their own.
module hash64_four_lane_mix #(
	parameter int OP_DEPTH  = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [63:0] length,
	input  logic [63:0] data_word,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] hash
);

	localparam int OP_W = $bits(h64flm_pkg::op_t);

	logic                  accept;
	logic                  fr_valid;
	h64flm_pkg::op_t       fr_op;
	logic [OP_W-1:0]       q_rdata;
	logic                  q_empty;
	logic                  q_pop;
	logic                  res_full;
	logic                  res_push;
	logic [63:0]           res_data;

	assign accept = push & ~full;

	// Decode incoming items.
	h64flm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (command),
		.length    (length),
		.data_word (data_word),
		.op_valid  (fr_valid),
		.op        (fr_op)
	);

	// Buffer operations between front and back.
	h64flm_fifo #(
		.WIDTH (OP_W),
		.DEPTH (OP_DEPTH)
	) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept & fr_valid),
		.wdata  (fr_op),
		.full   (full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Execute operations on the lanes.
	h64flm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (q_empty),
		.op       (h64flm_pkg::op_t'(q_rdata)),
		.op_pop   (q_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data)
	);

	// Hold finished hashes until popped.
	h64flm_fifo #(
		.WIDTH (64),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.rdata  (hash),
		.empty  (empty)
	);

endmodule

>>> sim/hash64_four_lane_mix_check.sv
// Checker for the four-lane hash block: predicts each message hash and compares transfers.
`timescale 1ns / 100ps

module hash64_four_lane_mix_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        command,
	input  logic [63:0] length,
	input  logic [63:0] data_word,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] hash,
	output int          mismatches,
	output int          hashes_due
);

	// Predicted lanes and message progress
	logic [63:0] lane_a, lane_b, lane_c, lane_d;
	logic [63:0] bytes_left;
	logic [2:0]  word_slot;
	bit          message_open;

	// Hashes predicted but not yet delivered, oldest first
	logic [63:0] hash_queue[$];
	logic [63:0] hash_want;

	function automatic logic [63:0] rol(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	// Run the twelve rotate-add-xor steps over the lanes.
	function void stir_lanes();
		logic [63:0] a, b, c, d;
		a = lane_a; b = lane_b; c = lane_c; d = lane_d;
		c = rol(c, 50) + d; a ^= c;
		d = rol(d, 52) + a; b ^= d;
		a = rol(a, 30) + b; c ^= a;
		b = rol(b, 41) + c; d ^= b;
		c = rol(c, 54) + d; a ^= c;
		d = rol(d, 48) + a; b ^= d;
		a = rol(a, 38) + b; c ^= a;
		b = rol(b, 37) + c; d ^= b;
		c = rol(c, 62) + d; a ^= c;
		d = rol(d, 34) + a; b ^= d;
		a = rol(a, 5) + b;  c ^= a;
		b = rol(b, 36) + c; d ^= b;
		lane_a = a; lane_b = b; lane_c = c; lane_d = d;
	endfunction

	// Close the message, queue its hash; a tail under four bytes, or none, adds the magic.
	function void close_message(input logic [63:0] tail_bytes);
		if (tail_bytes < 4) begin
			lane_c += h64flm_pkg::HASH_MAGIC;
			lane_d += h64flm_pkg::HASH_MAGIC;
		end
		stir_lanes();
		message_open = 1'b0;
		word_slot = '0;
		bytes_left = '0;
		hash_queue.push_back(lane_a + lane_b + lane_c + lane_d);
	endfunction

	// Fold one accepted item into the predicted state.
	function void absorb_item(input logic cmd, input logic [63:0] len, input logic [63:0] word);
		logic [63:0] group_bytes;
		logic [63:0] masked;
		logic [2:0]  group_words;
		if (h64flm_pkg::cmd_t'(cmd) == h64flm_pkg::CMD_START) begin
			lane_a = len + h64flm_pkg::HASH_MAGIC;
			lane_b = lane_a;
			lane_c = lane_a;
			lane_d = lane_a;
			bytes_left = len;
			word_slot = '0;
			message_open = 1'b1;
			if (len == 0)
				close_message(64'd0);
		end else if (message_open) begin
			group_bytes = bytes_left + 64'(word_slot) * 64'd8;
			if (group_bytes >= 16) begin
				// whole group or pair: add into the lane of this slot
				group_words = (group_bytes >= 32) ? 3'd4 : 3'd2;
				unique case (h64flm_pkg::lane_t'(word_slot[1:0]))
					h64flm_pkg::LANE_A: lane_a += word;
					h64flm_pkg::LANE_B: lane_b += word;
					h64flm_pkg::LANE_C: lane_c += word;
					default: lane_d += word;
				endcase
				bytes_left -= 8;
				word_slot++;
				if (word_slot >= group_words) begin
					stir_lanes();
					word_slot = '0;
					if (bytes_left == 0)
						close_message(64'd0);
				end
			end else begin
				// tail: drop bytes past the end, first word into c, second into d
				masked = word;
				if (bytes_left < 8)
					masked &= (64'd1 << (bytes_left * 8)) - 64'd1;
				if (word_slot == 0)
					lane_c += masked;
				else
					lane_d += masked;
				if (bytes_left <= 8) begin
					close_message(group_bytes);
				end else begin
					bytes_left -= 8;
					word_slot = 3'd1;
				end
			end
		end
	endfunction

	// Check result transfers first, then predict from input transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_a = '0; lane_b = '0; lane_c = '0; lane_d = '0;
			bytes_left = '0;
			word_slot = '0;
			message_open = 1'b0;
			hash_queue.delete();
			mismatches = 0;
			hashes_due = 0;
		end else begin
			if (pop && !empty) begin
				if (hash_queue.size() == 0) begin
					mismatches++;
					$display("%0t: hash %h delivered, expected none", $time, hash);
				end else begin
					hash_want = hash_queue.pop_front();
					if (hash !== hash_want) begin
						mismatches++;
						$display("%0t: hash expected %h, actual %h", $time, hash_want, hash);
					end
				end
			end
			if (push && !full)
				absorb_item(command, length, data_word);
			hashes_due = hash_queue.size();
		end
	end

endmodule

>>> sim/hash64_four_lane_mix_test.sv
// Testbench top for the four-lane hash block: message stimulus, idling and verdict.
`timescale 1ns / 100ps

module hash64_four_lane_mix_test;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        command;
	logic [63:0] length;
	logic [63:0] data_word;
	logic        empty;
	logic        pop;
	logic [63:0] hash;

	logic push_took, pop_took;
	int   mismatches, hashes_due;
	bit   feed_bursty, drain_bursty;

	hash64_four_lane_mix uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.length    (length),
		.data_word (data_word),
		.empty     (empty),
		.pop       (pop),
		.hash      (hash)
	);

	hash64_four_lane_mix_check check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.length     (length),
		.data_word  (data_word),
		.empty      (empty),
		.pop        (pop),
		.hash       (hash),
		.mismatches (mismatches),
		.hashes_due (hashes_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Record each transfer so the falling-edge drivers can see it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_took <= 1'b0;
			pop_took <= 1'b0;
		end else begin
			push_took <= push && !full;
			pop_took <= pop && !empty;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len(input bit bursty);
		int roll;
		if (!bursty)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Message lengths: mostly short, a few up to several hundred bytes.
	function automatic logic [63:0] msg_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 64'($urandom_range(0, 64));
		if (roll < 95)
			return 64'($urandom_range(65, 200));
		return 64'($urandom_range(201, 400));
	endfunction

	// Hold push high from the chosen falling edge until the item transfers.
	task automatic send(input h64flm_pkg::cmd_t cmd, input logic [63:0] len,
		input logic [63:0] word);
		int gap;
		gap = gap_len(feed_bursty);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		length <= len;
		data_word <= word;
		do @(negedge clk); while (!push_took);
	endtask

	// Start a message and deliver the given number of random words.
	task automatic feed_message(input logic [63:0] len, input int words);
		send(h64flm_pkg::CMD_START, len, rand64());
		repeat (words) send(h64flm_pkg::CMD_DATA, rand64(), rand64());
	endtask

	// Drain results with random stalls.
	initial begin
		int stall;
		pop = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (pop_took)
				stall = gap_len(drain_bursty);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		logic [63:0] len;
		int words, sent, roll, counted;
		arst_n = 1'b0;
		push = 1'b0;
		command = h64flm_pkg::CMD_START;
		length = '0;
		data_word = '0;
		feed_bursty = 1'b1;
		drain_bursty = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, stray data, tails around the magic threshold,
		// pair and group boundaries, an abandoned message of maximum length.
		send(h64flm_pkg::CMD_START, 64'd0, rand64());
		send(h64flm_pkg::CMD_DATA, rand64(), rand64());
		send(h64flm_pkg::CMD_START, 64'd3, '0);
		send(h64flm_pkg::CMD_DATA, '0, '1);
		send(h64flm_pkg::CMD_START, 64'd9, '0);
		send(h64flm_pkg::CMD_DATA, '0, '1);
		send(h64flm_pkg::CMD_DATA, '0, '1);
		feed_message(64'd12, 2);
		feed_message(64'd16, 2);
		feed_message(64'd32, 4);
		feed_message('1, 1);
		send(h64flm_pkg::CMD_START, 64'd8, '1);
		send(h64flm_pkg::CMD_DATA, '1, '1);

		// Random: mostly complete messages, some cut short, some stray traffic.
		counted = 0;
		while (counted < 1600) begin
			if ($urandom_range(0, 39) == 0) begin
				feed_bursty = $urandom_range(0, 3) != 0;
				drain_bursty = $urandom_range(0, 3) != 0;
			end
			roll = $urandom_range(0, 99);
			if (roll < 82) begin
				len = msg_len();
				words = int'((len + 7) / 8);
				feed_message(len, words);
				counted += words + 1;
				// stray word after the message closed
				if ($urandom_range(0, 9) == 0)
					send(h64flm_pkg::CMD_DATA, rand64(), rand64());
			end else if (roll < 94) begin
				len = msg_len();
				words = int'((len + 7) / 8);
				sent = (words == 0) ? 0 : $urandom_range(0, words - 1);
				feed_message(len, sent);
				counted += sent + 1;
			end else begin
				sent = $urandom_range(0, 5);
				feed_message(rand64(), sent);
				counted += sent + 1;
			end
		end

		// Wait for every predicted hash, then let the block settle.
		push <= 1'b0;
		while (hashes_due != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0)
			$display("hash64_four_lane_mix_test: clean");
		else
			$display("hash64_four_lane_mix_test: errors");
		$finish;
	end

	// Stop a hung run.
	initial begin
		#10_000_000;
		$display("hash64_four_lane_mix_test: errors");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/h64flm_pkg.sv
src/h64flm_fifo.sv
src/h64flm_front.sv
src/h64flm_back.sv
src/hash64_four_lane_mix.sv
sim/hash64_four_lane_mix_check.sv
sim/hash64_four_lane_mix_test.sv
